>>> rtl/core/ctlex_pkg.sv
// Shared types, token codes and character classifiers for the text lexer.
// No dependencies; imported by every lexer module.
package ctlex_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef logic [4:0] t_ttype;

    localparam t_ttype TT_ERR  = 5'd0;
    localparam t_ttype TT_SYM  = 5'd1;
    localparam t_ttype TT_INT  = 5'd2;
    localparam t_ttype TT_REAL = 5'd3;
    localparam t_ttype TT_STR  = 5'd4;
    localparam t_ttype TT_LPAR = 5'd5;
    localparam t_ttype TT_RPAR = 5'd6;
    localparam t_ttype TT_SEMI = 5'd7;
    localparam t_ttype TT_COLN = 5'd8;
    localparam t_ttype TT_COMA = 5'd9;
    localparam t_ttype TT_DOT  = 5'd10;
    localparam t_ttype TT_APOS = 5'd11;
    localparam t_ttype TT_PLUS = 5'd12;
    localparam t_ttype TT_MINS = 5'd13;
    localparam t_ttype TT_STAR = 5'd14;
    localparam t_ttype TT_SLSH = 5'd15;
    localparam t_ttype TT_CARE = 5'd16;
    localparam t_ttype TT_EQUL = 5'd17;
    localparam t_ttype TT_HASH = 5'd18;
    localparam t_ttype TT_BANG = 5'd19;
    localparam t_ttype TT_EOL  = 5'd20;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_SYM     = 3'd1,
        M_NUM     = 3'd2,
        M_NUMDOT  = 3'd3,
        M_STR     = 3'd4,
        M_DISCARD = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] token_char;
        logic       char_valid;
        t_ttype     token_type;
        logic       last;
    } t_result;

    // One queue entry: all results caused by one input byte.
    typedef struct packed {
        t_result r0;
        t_result r1;
        logic    two;
    } t_entry;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    // Returns TT_ERR for anything that is not a punctuation token.
    function automatic t_ttype punct_type(input logic [7:0] c);
        t_ttype t;
        unique case (c)
            8'h28:   t = TT_LPAR;
            8'h29:   t = TT_RPAR;
            8'h3B:   t = TT_SEMI;
            8'h3A:   t = TT_COLN;
            8'h2C:   t = TT_COMA;
            8'h2E:   t = TT_DOT;
            8'h27:   t = TT_APOS;
            8'h2B:   t = TT_PLUS;
            8'h2D:   t = TT_MINS;
            8'h2A:   t = TT_STAR;
            8'h2F:   t = TT_SLSH;
            8'h5E:   t = TT_CARE;
            8'h3D:   t = TT_EQUL;
            8'h23:   t = TT_HASH;
            8'h21:   t = TT_BANG;
            default: t = TT_ERR;
        endcase
        return t;
    endfunction

endpackage

>>> rtl/core/ctlex_front.sv
// Front end of the lexer: accepts bytes, runs the scan state machine and
// builds one queue entry per byte that gives results. Depends on ctlex_pkg.
module ctlex_front import ctlex_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_q_full,
    output logic       o_push,
    output t_entry     o_entry
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_held, n_held;
    logic       r_hv, n_hv;
    logic       r_real, n_real;

    logic       accept;
    logic [1:0] cnt;
    t_result    res0, res1;
    logic       do_begin;
    logic       b_emit;
    t_result    b_res;
    t_ttype     num_t, p_t;
    logic [7:0] c;

    assign c          = i_char_in;
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign num_t      = r_real ? TT_REAL : TT_INT;
    assign p_t        = punct_type(c);

    // results of the current byte
    always_comb begin
        cnt      = 2'd0;
        res0     = '0;
        res1     = '0;
        do_begin = 1'b0;
        b_emit   = 1'b0;
        b_res    = '0;

        unique case (r_mode)
            M_SYM: begin
                cnt  = 2'd1;
                res0 = '{token_char: r_held, char_valid: 1'b1, token_type: TT_SYM,
                         last: 1'b0};
                if (!(is_letter(c) || is_digit(c))) begin
                    res0.last = 1'b1;
                    do_begin  = 1'b1;
                end
            end
            M_NUM, M_NUMDOT: begin
                cnt  = 2'd1;
                res0 = '{token_char: r_held, char_valid: 1'b1, token_type: num_t,
                         last: 1'b0};
                if (!is_digit(c) && !(c == CH_DOT && r_mode == M_NUM)) begin
                    res0.last = 1'b1;
                    do_begin  = 1'b1;
                end
            end
            M_STR: begin
                if (c == CH_QUOTE || c == CH_NUL) begin
                    cnt  = 2'd1;
                    res0 = r_hv ? '{token_char: r_held, char_valid: 1'b1,
                                    token_type: TT_STR, last: 1'b1}
                                : '{token_char: 8'h00, char_valid: 1'b0,
                                    token_type: TT_STR, last: 1'b1};
                    if (c == CH_NUL) begin
                        cnt  = 2'd2;
                        res1 = '{token_char: 8'h00, char_valid: 1'b0,
                                 token_type: TT_EOL, last: 1'b1};
                    end
                end else if (r_hv) begin
                    cnt  = 2'd1;
                    res0 = '{token_char: r_held, char_valid: 1'b1,
                             token_type: TT_STR, last: 1'b0};
                end
            end
            M_DISCARD: begin
                // bytes give no result, up to and including the zero byte
            end
            default: begin
                do_begin = 1'b1;
            end
        endcase

        // start of a new token with the current byte
        if (do_begin) begin
            priority if (c == CH_NUL) begin
                b_emit = 1'b1;
                b_res  = '{token_char: 8'h00, char_valid: 1'b0, token_type: TT_EOL,
                          last: 1'b1};
            end else if (is_blank(c) || is_letter(c) || is_digit(c) || c == CH_QUOTE) begin
                b_emit = 1'b0;
            end else if (p_t != TT_ERR) begin
                b_emit = 1'b1;
                b_res  = '{token_char: c, char_valid: 1'b1, token_type: p_t, last: 1'b1};
            end else begin
                b_emit = 1'b1;
                b_res  = '{token_char: 8'h00, char_valid: 1'b0, token_type: TT_ERR,
                          last: 1'b1};
            end
            if (b_emit) begin
                if (cnt == 2'd0) res0 = b_res;
                else             res1 = b_res;
                cnt = cnt + 2'd1;
            end
        end
    end

    // next scan state
    always_comb begin
        n_mode = r_mode;
        n_held = r_held;
        n_hv   = r_hv;
        n_real = r_real;

        unique case (r_mode)
            M_SYM: begin
                if (is_letter(c) || is_digit(c)) n_held = c;
            end
            M_NUM, M_NUMDOT: begin
                if (is_digit(c)) begin
                    n_held = c;
                    n_mode = M_NUM;
                end else if (c == CH_DOT && r_mode == M_NUM) begin
                    n_held = c;
                    n_real = 1'b1;
                    n_mode = M_NUMDOT;
                end
            end
            M_STR: begin
                if (c == CH_QUOTE || c == CH_NUL) begin
                    n_hv   = 1'b0;
                    n_mode = M_IDLE;
                end else begin
                    n_held = c;
                    n_hv   = 1'b1;
                end
            end
            M_DISCARD: begin
                if (c == CH_NUL) n_mode = M_IDLE;
            end
            default: begin
                // idle: handled as a token start below
            end
        endcase

        if (do_begin) begin
            n_mode = M_IDLE;
            n_hv   = 1'b0;
            if (is_letter(c)) begin
                n_mode = M_SYM;
                n_held = c;
                n_hv   = 1'b1;
            end else if (is_digit(c)) begin
                n_mode = M_NUM;
                n_real = 1'b0;
                n_held = c;
                n_hv   = 1'b1;
            end else if (c == CH_QUOTE) begin
                n_mode = M_STR;
            end else if (!is_blank(c) && c != CH_NUL && p_t == TT_ERR) begin
                n_mode = M_DISCARD;
            end
        end
    end

    assign o_push  = accept && (cnt != 2'd0);
    assign o_entry = '{r0: res0, r1: res1, two: (cnt == 2'd2)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_held <= 8'h00;
            r_hv   <= 1'b0;
            r_real <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_hv   <= n_hv;
            r_real <= n_real;
        end
    end

endmodule

>>> rtl/core/ctlex_queue.sv
// Short entry queue between the lexer front and back ends.
// Depends on ctlex_pkg.
module ctlex_queue import ctlex_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

endmodule

>>> rtl/core/ctlex_back.sv
// Back end of the lexer: takes queue entries and delivers their results one
// transaction at a time from an output register. Depends on ctlex_pkg.
module ctlex_back import ctlex_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_entry  i_head,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    t_entry r_entry;
    logic   r_sel, n_sel;
    logic   r_busy, n_busy;
    logic   done;

    // current entry is finished after this transaction
    assign done        = i_out_ready && (r_sel || !r_entry.two);
    assign o_pop       = !i_q_empty && (!r_busy || done);
    assign o_out_valid = r_busy;
    assign o_result    = r_sel ? r_entry.r1 : r_entry.r0;

    always_comb begin
        n_sel  = r_sel;
        n_busy = r_busy;
        if (o_pop) begin
            n_sel  = 1'b0;
            n_busy = 1'b1;
        end else if (r_busy && i_out_ready) begin
            if (done) n_busy = 1'b0;
            else      n_sel  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel  <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            r_sel  <= n_sel;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_entry <= i_head;
    end

endmodule

>>> rtl/core/config_text_lexer_unit.sv
// Top level of the configuration text lexer.
// Depends on ctlex_pkg, ctlex_front, ctlex_queue and ctlex_back.
//
// Bytes of text enter one per transaction on the input channel; tokens leave
// as a stream of character results, each tagged with its token type, with
// o_last marking the final result of a token (its type is final there). One
// character of a symbol, number or string is held back until the next byte
// shows where the token ends. A zero byte ends the line and, outside a
// discard run, gives an end-of-line result with no character; an unexpected
// byte gives an error result and the bytes that follow, up to and including
// the next zero byte, are dropped. Rate: one byte is accepted every cycle
// while the four-entry queue between the scanner and the output stage has
// room. A byte causes at most two results: two when it ends a held symbol or
// number and also gives a result of its own (punctuation, error or end of
// line), or when it is a zero byte that closes an open string. Each result is
// one output transaction; the output side sets the sustained rate at one
// result per cycle while i_out_ready is high. The scan writes the queue at
// the edge that accepts a byte; the output register loads the entry from the
// queue once the output stage is done with the previous entry.
module config_text_lexer_unit import ctlex_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    // token result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_token_char,
    output logic       o_char_valid,
    output logic [4:0] o_token_type,
    output logic       o_last
);

    logic    push, pop, q_full, q_empty;
    t_entry  push_entry, head_entry;
    t_result result;

    // scanner: classifies each byte and tracks token state
    ctlex_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_char_in  (i_char_in),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // decouples scanner from output backpressure
    ctlex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_entry)
    );

    // output stage: splits two-result entries into two transactions
    ctlex_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_token_char = result.token_char;
    assign o_char_valid = result.char_valid;
    assign o_token_type = result.token_type;
    assign o_last       = result.last;

endmodule

>>> dv/ctlex_token_checker.sv
// Token checker for the config text lexer: watches both channels, predicts the
// token results of every accepted byte and compares them in order.
// Depends on ctlex_pkg for the token codes, scan modes and result layout.
`timescale 1ns / 1ps

module ctlex_token_checker import ctlex_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_token_char,
    input  logic       i_char_valid,
    input  logic [4:0] i_token_type,
    input  logic       i_last,
    input  logic       i_drain_check,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    localparam int MAX_LINES = 40;

    // Predicted lexer state
    t_mode      scan_state;
    logic [7:0] held_byte;
    logic       held_present;
    logic       number_real;

    t_result    expected_tokens[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_mismatch(input string what);
        o_fail_count++;
        if (o_fail_count <= MAX_LINES) begin
            $display("[%0t] checker: %s", $time, what);
        end
    endtask

    function automatic logic letter_ch(input logic [7:0] c);
        return c inside {["A":"Z"], ["a":"z"]};
    endfunction

    function automatic logic digit_ch(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic blank_ch(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    // Punctuation and operator bytes; TT_ERR for anything else
    function automatic t_ttype single_char_type(input logic [7:0] c);
        case (c)
            "(":     return TT_LPAR;
            ")":     return TT_RPAR;
            ";":     return TT_SEMI;
            ":":     return TT_COLN;
            ",":     return TT_COMA;
            ".":     return TT_DOT;
            "'":     return TT_APOS;
            "+":     return TT_PLUS;
            "-":     return TT_MINS;
            "*":     return TT_STAR;
            "/":     return TT_SLSH;
            "^":     return TT_CARE;
            "=":     return TT_EQUL;
            "#":     return TT_HASH;
            "!":     return TT_BANG;
            default: return TT_ERR;
        endcase
    endfunction

    task automatic add_result(input logic [7:0] ch, input logic cv, input t_ttype ty,
                              input logic lst);
        t_result r;
        r.token_char = ch;
        r.char_valid = cv;
        r.token_type = ty;
        r.last       = lst;
        expected_tokens.push_back(r);
    endtask

    // First byte of a new token, or a byte seen between tokens
    task automatic start_token(input logic [7:0] c);
        t_ttype p;
        p = single_char_type(c);
        scan_state   = M_IDLE;
        held_present = 1'b0;
        if (blank_ch(c)) begin
            // separator only
        end else if (c == CH_NUL) begin
            add_result(8'h00, 1'b0, TT_EOL, 1'b1);
        end else if (letter_ch(c)) begin
            scan_state   = M_SYM;
            held_byte    = c;
            held_present = 1'b1;
        end else if (digit_ch(c)) begin
            scan_state   = M_NUM;
            number_real  = 1'b0;
            held_byte    = c;
            held_present = 1'b1;
        end else if (c == CH_QUOTE) begin
            scan_state = M_STR;
        end else if (p != TT_ERR) begin
            add_result(c, 1'b1, p, 1'b1);
        end else begin
            scan_state = M_DISCARD;
            add_result(8'h00, 1'b0, TT_ERR, 1'b1);
        end
    endtask

    task automatic scan_byte(input logic [7:0] c);
        t_ttype num_ty;
        num_ty = number_real ? TT_REAL : TT_INT;
        case (scan_state)
            M_SYM: begin
                if (letter_ch(c) || digit_ch(c)) begin
                    add_result(held_byte, 1'b1, TT_SYM, 1'b0);
                    held_byte = c;
                end else begin
                    add_result(held_byte, 1'b1, TT_SYM, 1'b1);
                    start_token(c);
                end
            end
            M_NUM, M_NUMDOT: begin
                if (digit_ch(c)) begin
                    add_result(held_byte, 1'b1, num_ty, 1'b0);
                    held_byte  = c;
                    scan_state = M_NUM;
                end else if (c == CH_DOT && scan_state == M_NUM) begin
                    // type on the held digit is still the one known so far
                    add_result(held_byte, 1'b1, num_ty, 1'b0);
                    held_byte   = c;
                    number_real = 1'b1;
                    scan_state  = M_NUMDOT;
                end else begin
                    add_result(held_byte, 1'b1, num_ty, 1'b1);
                    start_token(c);
                end
            end
            M_STR: begin
                if (c == CH_QUOTE || c == CH_NUL) begin
                    if (held_present) begin
                        add_result(held_byte, 1'b1, TT_STR, 1'b1);
                    end else begin
                        add_result(8'h00, 1'b0, TT_STR, 1'b1);
                    end
                    held_present = 1'b0;
                    scan_state   = M_IDLE;
                    if (c == CH_NUL) begin
                        add_result(8'h00, 1'b0, TT_EOL, 1'b1);
                    end
                end else begin
                    if (held_present) begin
                        add_result(held_byte, 1'b1, TT_STR, 1'b0);
                    end
                    held_byte    = c;
                    held_present = 1'b1;
                end
            end
            M_DISCARD: begin
                if (c == CH_NUL) begin
                    scan_state = M_IDLE;
                end
            end
            default: begin
                start_token(c);
            end
        endcase
    endtask

    task automatic compare_result();
        t_result want;
        if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected result char %h valid %b type %0d last %b",
                                      i_token_char, i_char_valid, i_token_type, i_last));
        end else begin
            want = expected_tokens.pop_front();
            if (i_token_char !== want.token_char) begin
                report_mismatch($sformatf("result %0d: token_char %h, expected %h",
                                          o_checked, i_token_char, want.token_char));
            end
            if (i_char_valid !== want.char_valid) begin
                report_mismatch($sformatf("result %0d: char_valid %b, expected %b",
                                          o_checked, i_char_valid, want.char_valid));
            end
            if (i_token_type !== want.token_type) begin
                report_mismatch($sformatf("result %0d: token_type %0d, expected %0d",
                                          o_checked, i_token_type, want.token_type));
            end
            if (i_last !== want.last) begin
                report_mismatch($sformatf("result %0d: last %b, expected %b",
                                          o_checked, i_last, want.last));
            end
        end
        o_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_state   = M_IDLE;
            held_byte    = 8'h00;
            held_present = 1'b0;
            number_real  = 1'b0;
            expected_tokens.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_result();
            end
            if (i_in_valid && i_in_ready) begin
                scan_byte(i_char_in);
            end
            if (i_drain_check) begin
                while (expected_tokens.size() != 0) begin
                    report_mismatch($sformatf("expected result never arrived: type %0d",
                                              expected_tokens[0].token_type));
                    void'(expected_tokens.pop_front());
                end
            end
        end
        o_pending = expected_tokens.size();
    end

endmodule

>>> dv/testbench.sv
// Top of the lexer testbench: clock, reset, byte stimulus and the verdict.
// Depends on ctlex_pkg, config_text_lexer_unit and ctlex_token_checker.
`timescale 1ns / 1ps

module testbench import ctlex_pkg::*; ();

    localparam int  ITEM_TARGET  = 1670;
    localparam int  IDLE_PCT     = 22;
    // hold-off window (in bytes sent) with no idling on either side
    localparam int  BURST_FROM   = 600;
    localparam int  BURST_TO     = 950;
    localparam int  DIRECTED_LEN = 28;
    localparam real TIMEOUT_NS   = 1_000_000.0;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] char_in;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] token_char;
    logic       char_valid;
    logic [4:0] token_type;
    logic       tok_last;
    logic       drain_check = 1'b0;

    // Registered copy of the input handshake; read at the falling edge it tells
    // the driver whether the byte on the bus went in at the last rising edge.
    logic       in_taken = 1'b0;

    int         fail_count;
    int         pending;
    int         checked;
    int         bytes_sent = 0;
    int         gap_pct    = IDLE_PCT;
    int         stall_pct  = IDLE_PCT;

    // Directed text: a symbol ended by punctuation, every punctuation and
    // operator byte, a real closed by a second dot, an empty string, a string
    // cut short by the end of line, an illegal top-bit byte with its discard
    // run, and a bare end of line.
    logic [7:0] directed_text [DIRECTED_LEN] = '{
        "Z", "9", "(", ")", ";", ":", ",", ".", "'", "+", "-", "*", "/", "^",
        "=", "#", "!", "0", ".", ".", CH_QUOTE, CH_QUOTE, CH_QUOTE, "a",
        CH_NUL, 8'hFF, CH_NUL, CH_NUL
    };

    logic [7:0] punct_chars [15] = '{
        "(", ")", ";", ":", ",", ".", "'", "+", "-", "*", "/", "^", "=", "#", "!"
    };

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    config_text_lexer_unit u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_char_in    (char_in),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_token_char (token_char),
        .o_char_valid (char_valid),
        .o_token_type (token_type),
        .o_last       (tok_last)
    );

    ctlex_token_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_char_in     (char_in),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_token_char  (token_char),
        .i_char_valid  (char_valid),
        .i_token_type  (token_type),
        .i_last        (tok_last),
        .i_drain_check (drain_check),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always @(posedge clk) begin
        in_taken <= rst_n && in_valid && in_ready;
    end

    // Result side backpressure: each cycle stalls on its own draw at the current rate
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("testbench: FAIL");
        $finish;
    end

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(1) == 0) ? 8'("A" + $urandom_range(25))
                                        : 8'("a" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Present one byte and hold it until the lexer takes it. Called and
    // returning at a falling edge; an optional idle gap comes first, so valid
    // drops only when a gap is really inserted. Each idle cycle is drawn on
    // its own, which keeps the idle share of cycles at the gap rate.
    task automatic put_byte(input logic [7:0] b);
        if (gap_pct != 0) begin
            while ($urandom_range(99) < gap_pct) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        char_in  <= b;
        do begin
            @(negedge clk);
        end while (!in_taken);
        bytes_sent++;
    endtask

    // One line of well-formed tokens with random content, ended by a zero
    // byte. Some lines are broken: an unterminated string, or a noise byte
    // that usually sends the lexer into its discard state.
    task automatic send_line();
        int         n_tok;
        int         kind;
        int         len;
        logic [7:0] c;
        n_tok = $urandom_range(8, 1);
        for (int t = 0; t < n_tok; t++) begin
            kind = $urandom_range(99);
            if (kind < 22) begin
                // symbol: letter, then letters and digits
                put_byte(rand_letter());
                len = $urandom_range(5);
                repeat (len) begin
                    put_byte(($urandom_range(2) == 0) ? rand_digit() : rand_letter());
                end
            end else if (kind < 40) begin
                // integer, sometimes made real, sometimes with a double dot
                len = $urandom_range(4, 1);
                repeat (len) put_byte(rand_digit());
                if ($urandom_range(2) == 0) begin
                    put_byte(CH_DOT);
                    if ($urandom_range(5) == 0) begin
                        put_byte(CH_DOT);
                    end else begin
                        len = $urandom_range(3);
                        repeat (len) put_byte(rand_digit());
                    end
                end
            end else if (kind < 60) begin
                // string with any bytes but quote and zero, empty at times
                put_byte(CH_QUOTE);
                len = $urandom_range(6);
                repeat (len) begin
                    do begin
                        c = 8'($urandom_range(255, 1));
                    end while (c == CH_QUOTE);
                    put_byte(c);
                end
                if ($urandom_range(9) == 0) begin
                    // unterminated: the zero byte closes string and line
                    put_byte(CH_NUL);
                    return;
                end
                put_byte(CH_QUOTE);
            end else if (kind < 88) begin
                put_byte(punct_chars[$urandom_range(14)]);
            end else begin
                // noise, then end the line so the discard run stays short
                put_byte(8'($urandom_range(255)));
                put_byte(CH_NUL);
                return;
            end
            // tokens either abut (end seen on the next token byte) or are
            // separated by a run of blanks
            if ($urandom_range(99) < 60) begin
                len = $urandom_range(2, 1);
                repeat (len) put_byte(rand_blank());
            end
        end
        put_byte(CH_NUL);
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_in   = 8'h00;
        out_ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_LEN; i++) begin
            put_byte(directed_text[i]);
        end

        while (bytes_sent < ITEM_TARGET) begin
            // a long burst with both sides running flat out
            if (bytes_sent >= BURST_FROM && bytes_sent < BURST_TO) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = IDLE_PCT;
                stall_pct = IDLE_PCT;
            end
            send_line();
        end
        in_valid <= 1'b0;

        // drain, then give the pipeline room to show strays
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        drain_check <= 1'b1;
        @(negedge clk);
        drain_check <= 1'b0;
        @(negedge clk);

        $display("summary: %0d bytes sent as directed text and random token lines", bytes_sent);
        $display("summary: %0d token results compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
